// ===== hw/rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2
  } func_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic   do_insert;
    logic   do_remove;
    value_t value;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// top level of the sorted priority queue
//
// holds up to CAPACITY signed 32-bit values in descending order, largest at
// the head, in a row of cells that each keep one entry. every cell compares
// its entry with the broadcast value and picks its next entry from itself,
// its left neighbour, its right neighbour or the broadcast value, so an
// insert or remove rearranges the whole row at once.
//
// input channel: in_func (insert, remove first equal, find) and in_value,
// taken when in_valid is high and in_stall low. each item yields exactly one
// result on the output channel: ok, full_res, position, head_value,
// head_valid and count, as the queue stands after the operation.
//
// the result is registered: it sits in the output register the edge after
// the item is taken. throughput is one item per cycle while no result is
// held by out_stall.
// when out_stall holds the result, in_stall rises and no new item is taken
// until the result is gone.
// reset (rst_n low, synchronous) empties the queue and drops any pending
// result; entry contents are left as they are.
module sorted_priority_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spq_pkg::FUNC_W-1:0]    in_func,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic                          out_full_res,
  output logic [spq_pkg::POS_W-1:0]     out_position,
  output logic signed [31:0]            out_head_value,
  output logic                          out_head_valid,
  output logic [spq_pkg::COUNT_W-1:0]   out_count
);

  localparam int N = spq_pkg::CAPACITY;

  logic                      in_accept;
  logic [spq_pkg::CNT_W-1:0] count_r, count_nxt;
  spq_pkg::cell_ctl_t        ctl;
  logic                      is_insert, is_remove, is_find;
  logic                      full;
  logic                      hit;
  logic [spq_pkg::IDX_W-1:0] hit_pos;

  // per-cell wires
  spq_pkg::value_t           entry   [N];
  spq_pkg::value_t           entry_n [N];
  logic [N-1:0]              gt, eq, cell_valid;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic                      ok_nxt;
  logic                      ok_r, full_r, head_valid_r;
  logic [spq_pkg::POS_W-1:0] pos_r;
  logic [spq_pkg::POS_W-1:0] pos_nxt;
  spq_pkg::value_t           head_r, head_nxt;
  logic [spq_pkg::COUNT_W-1:0] cnt_out_r;

  // a held result blocks the input side
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign is_insert = in_accept && (in_func == spq_pkg::FUNC_INSERT);
  assign is_remove = in_accept && (in_func == spq_pkg::FUNC_REMOVE);
  assign is_find   = in_accept && (in_func == spq_pkg::FUNC_FIND);
  assign full      = (count_r == spq_pkg::CNT_W'(N));

  assign ctl.value     = in_value;
  assign ctl.do_insert = is_insert & ~full;
  assign ctl.do_remove = is_remove & hit;

  // the row of cells; the head sees a virtual larger neighbour on its left
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_valid[i] = (spq_pkg::CNT_W'(i) < count_r);

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cell_valid  (cell_valid[i]),
      .left_gt     ((i == 0) ? 1'b1 : gt[(i == 0) ? 0 : i-1]),
      .left_entry  (entry[(i == 0) ? 0 : i-1]),
      .right_entry (entry[(i == N-1) ? i : i+1]),
      .entry_r     (entry[i]),
      .entry_nxt   (entry_n[i]),
      .gt          (gt[i]),
      .eq          (eq[i])
    );
  end

  spq_find u_find (
    .eq       (eq),
    .hit      (hit),
    .position (hit_pos)
  );

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (ctl.do_insert) begin
      count_nxt = count_r + spq_pkg::CNT_W'(1);
    end else if (ctl.do_remove) begin
      count_nxt = count_r - spq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result fields as they stand after the operation
  assign ok_nxt   = ctl.do_insert | ctl.do_remove | (is_find & hit);
  assign pos_nxt  = (is_find & hit) ? spq_pkg::POS_W'(hit_pos) : '0;
  assign head_nxt = (count_nxt != '0) ? entry_n[0] : '0;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ok_r         <= ok_nxt;
      full_r       <= is_insert & full;
      pos_r        <= pos_nxt;
      head_r       <= head_nxt;
      head_valid_r <= (count_nxt != '0);
      cnt_out_r    <= spq_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_full_res   = full_r;
  assign out_position   = pos_r;
  assign out_head_value = head_r;
  assign out_head_valid = head_valid_r;
  assign out_count      = cnt_out_r;

  // count never runs past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  // head of the row is never below the next entry
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= spq_pkg::CNT_W'(2)) |-> (entry[0] >= entry[1]))
    else $error("chain out of order at the head");

  // a refused insert never reports success
  a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ok_r && full_r))
    else $error("result both ok and full");

  // a successful insert grows the queue by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_insert |=> (count_r == $past(count_r) + spq_pkg::CNT_W'(1)))
    else $error("insert did not grow the queue");

  // reported head flag follows the reported count
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (head_valid_r == (cnt_out_r != '0)))
    else $error("head flag disagrees with count");

endmodule

// ===== hw/rtl/spq_cell.sv =====
// one storage cell of the sorted chain
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               cell_valid,
  input  logic               left_gt,
  input  spq_pkg::value_t    left_entry,
  input  spq_pkg::value_t    right_entry,
  output spq_pkg::value_t    entry_r,
  output spq_pkg::value_t    entry_nxt,
  output logic               gt,
  output logic               eq
);

  assign gt = cell_valid && (entry_r > ctl.value);
  assign eq = cell_valid && (entry_r == ctl.value);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_insert && !gt) begin
      // the first cell not above the new value takes it, later ones shift down
      entry_nxt = left_gt ? ctl.value : left_entry;
    end else if (ctl.do_remove && !gt) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hw/rtl/spq_find.sv =====
// match detection and position encoding across the chain
module spq_find (
  input  logic [spq_pkg::CAPACITY-1:0] eq,
  output logic                         hit,
  output logic [spq_pkg::IDX_W-1:0]    position
);

  logic [spq_pkg::CAPACITY-1:0] first;

  // equal entries sit together, so the first match is where a run starts
  always_comb begin
    first[0] = eq[0];
    for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
      first[i] = eq[i] & ~eq[i-1];
    end
  end

  always_comb begin
    position = '0;
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      if (first[i]) begin
        position = position | spq_pkg::IDX_W'(i);
      end
    end
  end

  assign hit = |eq;

endmodule
